// File: hw/rtl/mi3_pkg.sv
// Shared types and constants for the 3x3 matrix inverse pipeline.
// No dependencies; imported by every module of the block.
package mi3_pkg;

    localparam int unsigned NUM_ELEM = 9;

    // adjugate entry k = m[a]*m[b] - m[c]*m[d], flat row-major indices
    localparam logic [3:0] ADJ_TAB [NUM_ELEM][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    // control that travels with every pipeline slot
    typedef struct packed {
        logic valid;
        logic sing;
    } mi3_ctl_t;

endpackage

// File: hw/rtl/mi3_front.sv
// Front end: adjugate products, adjugate, determinant and divider setup.
// Six register stages; depends on mi3_pkg.
module mi3_front #(
    parameter int W  = 32,
    parameter int F  = 16,
    parameter int DW = 3 * W + 2,
    parameter int RW = 4 * W + 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [W-1:0]         in_elem [9],
    output mi3_pkg::mi3_ctl_t    out_ctl,
    output logic [RW-1:0]        out_rem [9],
    output logic [DW-1:0]        out_dmag,
    output logic                 out_neg [9],
    output logic                 out_big [9]
);
    import mi3_pkg::*;

    localparam int AW = 2 * W + 1;
    localparam int PW = 2 * W + 1;

    // stage A: inputs
    logic                 va_reg;
    logic signed [W-1:0]  ma_reg [9];
    // stage B: element products
    logic                 vb_reg;
    logic signed [2*W-1:0] pa_reg [9];
    logic signed [2*W-1:0] pb_reg [9];
    logic signed [W-1:0]  mb_reg [3];
    // stage C: adjugate
    logic                 vc_reg;
    logic signed [AW-1:0] adjc_reg [9];
    logic signed [W-1:0]  mc_reg [3];
    // stage D: determinant partial products
    logic                 vd_reg;
    logic signed [PW-1:0] pl_reg [3];
    logic signed [PW+1:0] ph_reg [3];
    logic signed [AW-1:0] adjd_reg [9];
    // stage E: determinant
    logic                 ve_reg;
    logic signed [DW-1:0] det_reg;
    logic signed [AW-1:0] adje_reg [9];
    // stage F: setup, output
    mi3_ctl_t             ctl_reg;
    logic [RW-1:0]        rem_reg [9];
    logic [DW-1:0]        dmag_reg;
    logic                 neg_reg [9];
    logic                 big_reg [9];

    logic signed [DW-1:0] det_next;
    logic [DW-1:0]        dmag_next;
    logic                 dneg;
    logic [RW-1:0]        num_next [9];
    logic [RW-1:0]        dlim;

    always_comb begin
        det_next = '0;
        for (int i = 0; i < 3; i++) begin
            det_next = det_next + (DW'(ph_reg[i]) <<< W) + DW'(pl_reg[i]);
        end
    end

    assign dneg      = det_reg[DW-1];
    assign dmag_next = dneg ? DW'(-det_reg) : DW'(det_reg);
    assign dlim      = RW'(dmag_next) << (W + 1);

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            num_next[k] = (adje_reg[k][AW-1] ? RW'(-adje_reg[k]) : RW'(adje_reg[k]))
                          << (2 * F);
            num_next[k] = num_next[k] & ((RW'(1) << (AW + 2 * F)) - RW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg  <= 1'b0;
            vb_reg  <= 1'b0;
            vc_reg  <= 1'b0;
            vd_reg  <= 1'b0;
            ve_reg  <= 1'b0;
            ctl_reg <= '0;
        end else if (en) begin
            va_reg        <= in_valid;
            vb_reg        <= va_reg;
            vc_reg        <= vb_reg;
            vd_reg        <= vc_reg;
            ve_reg        <= vd_reg;
            ctl_reg.valid <= ve_reg;
            ctl_reg.sing  <= (det_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                ma_reg[k]   <= in_elem[k];
                pa_reg[k]   <= ma_reg[ADJ_TAB[k][0]] * ma_reg[ADJ_TAB[k][1]];
                pb_reg[k]   <= ma_reg[ADJ_TAB[k][2]] * ma_reg[ADJ_TAB[k][3]];
                adjc_reg[k] <= AW'(pa_reg[k]) - AW'(pb_reg[k]);
                adjd_reg[k] <= adjc_reg[k];
                adje_reg[k] <= adjd_reg[k];
                rem_reg[k]  <= num_next[k];
                neg_reg[k]  <= adje_reg[k][AW-1] ^ dneg;
                big_reg[k]  <= (num_next[k] >= dlim);
            end
            for (int i = 0; i < 3; i++) begin
                mb_reg[i] <= ma_reg[i];
                mc_reg[i] <= mb_reg[i];
            end
            // first-row expansion uses adjugate entries 0, 3, 6
            for (int i = 0; i < 3; i++) begin
                pl_reg[i] <= mc_reg[i] * $signed({1'b0, adjc_reg[3*i][W-1:0]});
                ph_reg[i] <= mc_reg[i] * $signed(adjc_reg[3*i][AW-1:W]);
            end
            det_reg  <= det_next;
            dmag_reg <= dmag_next;
        end
    end

    assign out_ctl  = ctl_reg;
    assign out_rem  = rem_reg;
    assign out_dmag = dmag_reg;
    assign out_neg  = neg_reg;
    assign out_big  = big_reg;

endmodule

// File: hw/rtl/mi3_div_step.sv
// One restoring division step for all nine lanes: produces quotient bit J.
// Depends on mi3_pkg.
module mi3_div_step #(
    parameter int W  = 32,
    parameter int J  = 0,
    parameter int DW = 3 * W + 2,
    parameter int RW = 4 * W + 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  mi3_pkg::mi3_ctl_t  in_ctl,
    input  logic [RW-1:0]      in_rem [9],
    input  logic [W:0]         in_quo [9],
    input  logic [DW-1:0]      in_dmag,
    input  logic               in_neg [9],
    input  logic               in_big [9],
    output mi3_pkg::mi3_ctl_t  out_ctl,
    output logic [RW-1:0]      out_rem [9],
    output logic [W:0]         out_quo [9],
    output logic [DW-1:0]      out_dmag,
    output logic               out_neg [9],
    output logic               out_big [9]
);
    import mi3_pkg::*;

    mi3_ctl_t      ctl_reg;
    logic [RW-1:0] rem_reg [9];
    logic [W:0]    quo_reg [9];
    logic [DW-1:0] dmag_reg;
    logic          neg_reg [9];
    logic          big_reg [9];
    logic [RW-1:0] trial;

    assign trial = RW'(in_dmag) << J;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dmag_reg <= in_dmag;
            for (int k = 0; k < 9; k++) begin
                neg_reg[k] <= in_neg[k];
                big_reg[k] <= in_big[k];
                if (in_rem[k] >= trial) begin
                    rem_reg[k] <= in_rem[k] - trial;
                    quo_reg[k] <= in_quo[k] | ((W+1)'(1) << J);
                end else begin
                    rem_reg[k] <= in_rem[k];
                    quo_reg[k] <= in_quo[k];
                end
            end
        end
    end

    assign out_ctl  = ctl_reg;
    assign out_rem  = rem_reg;
    assign out_quo  = quo_reg;
    assign out_dmag = dmag_reg;
    assign out_neg  = neg_reg;
    assign out_big  = big_reg;

endmodule

// File: hw/rtl/matrix3x3_inverse.sv
// Top level of the 3x3 matrix inverse: front end, divider chain, output skid.
// Depends on mi3_pkg, mi3_front and mi3_div_step.
//
// Usage:
//   Slave channel s_*: one 3x3 matrix per transaction, nine signed fixed-point
//   elements of ELEM_WIDTH bits with FRAC_BITS fraction bits, row-major.
//   Master channel m_*: the inverse in the same layout; tuser carries the
//   singular flag (identity returned) and the overflow flag (saturation).
//   Pipeline: 6 front-end stages, ELEM_WIDTH+1 quotient-bit stages and one
//   output register lie between acceptance and m_tvalid.
//   Throughput: one matrix per cycle while s_tready is high; each restoring
//   divider stage resolves one quotient bit for all nine lanes.
//   Reset clears every valid bit; no transaction is in flight afterwards.
//   Stall: when m_tready is low one more result is held in a skid register;
//   s_tready drops only while that skid register is full, and the whole
//   pipeline freezes without losing or repeating a transaction.
module matrix3x3_inverse #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // in_r0c0, in_r0c1, ... in_r2c2 (ELEM_WIDTH each), zero fill
    input  logic [((9*ELEM_WIDTH+7)/8)*8-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_r0c0, out_r0c1, ... out_r2c2 (ELEM_WIDTH each), zero fill
    output logic [((9*ELEM_WIDTH+7)/8)*8-1:0]   m_tdata,
    // singular, overflow
    output logic [1:0]                          m_tuser
);
    import mi3_pkg::*;

    localparam int W   = ELEM_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int DW  = 3 * W + 2;
    localparam int NW  = 2 * W + 1 + 2 * F;
    localparam int RW0 = (NW > DW + W + 1) ? NW : DW + W + 1;
    localparam int RW  = RW0 + 1;
    localparam int TW  = ((9 * W + 7) / 8) * 8;
    localparam int OW  = 9 * W + 2;
    localparam logic [W:0] MAXPOS = (W+1)'((64'd1 << (W - 1)) - 64'd1);
    localparam logic [W:0] MAXNEG = (W+1)'(64'd1 << (W - 1));
    localparam logic [W-1:0] ONE_VAL = (F >= W - 1) ? MAXPOS[W-1:0] : W'(64'd1 << F);
    localparam logic ONE_OVF = (F >= W - 1);

    logic          en;
    logic [W-1:0]  elem [9];

    mi3_ctl_t      ch_ctl  [W+2];
    logic [RW-1:0] ch_rem  [W+2][9];
    logic [W:0]    ch_quo  [W+2][9];
    logic [DW-1:0] ch_dmag [W+2];
    logic          ch_neg  [W+2][9];
    logic          ch_big  [W+2][9];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            elem[k] = s_tdata[k*W +: W];
        end
    end

    mi3_front #(.W(W), .F(F), .DW(DW), .RW(RW)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_elem  (elem),
        .out_ctl  (ch_ctl[0]),
        .out_rem  (ch_rem[0]),
        .out_dmag (ch_dmag[0]),
        .out_neg  (ch_neg[0]),
        .out_big  (ch_big[0])
    );

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            ch_quo[0][k] = '0;
        end
    end

    for (genvar s = 0; s <= W; s++) begin : g_div
        mi3_div_step #(.W(W), .J(W - s), .DW(DW), .RW(RW)) u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_ctl   (ch_ctl[s]),
            .in_rem   (ch_rem[s]),
            .in_quo   (ch_quo[s]),
            .in_dmag  (ch_dmag[s]),
            .in_neg   (ch_neg[s]),
            .in_big   (ch_big[s]),
            .out_ctl  (ch_ctl[s+1]),
            .out_rem  (ch_rem[s+1]),
            .out_quo  (ch_quo[s+1]),
            .out_dmag (ch_dmag[s+1]),
            .out_neg  (ch_neg[s+1]),
            .out_big  (ch_big[s+1])
        );
    end

    // saturate and sign the quotients, or substitute the identity
    logic [OW-1:0] res_next;
    logic          ovf;
    logic [W-1:0]  val;
    always_comb begin
        ovf      = 1'b0;
        res_next = '0;
        for (int k = 0; k < 9; k++) begin
            if (ch_ctl[W+1].sing) begin
                val = (k % 4 == 0) ? ONE_VAL : '0;
            end else if (ch_neg[W+1][k]) begin
                if (ch_big[W+1][k] || ch_quo[W+1][k] > MAXNEG) begin
                    val = MAXNEG[W-1:0];
                    ovf = 1'b1;
                end else begin
                    val = W'(-ch_quo[W+1][k]);
                end
            end else begin
                if (ch_big[W+1][k] || ch_quo[W+1][k] > MAXPOS) begin
                    val = MAXPOS[W-1:0];
                    ovf = 1'b1;
                end else begin
                    val = ch_quo[W+1][k][W-1:0];
                end
            end
            res_next[k*W +: W] = val;
        end
        if (ch_ctl[W+1].sing) begin
            ovf = ONE_OVF;
        end
        res_next[9*W]     = ch_ctl[W+1].sing;
        res_next[9*W + 1] = ovf;
    end

    logic          out_valid_reg;
    logic          skid_valid_reg;
    logic [OW-1:0] out_data_reg;
    logic [OW-1:0] skid_data_reg;
    logic          lv;

    assign en = !skid_valid_reg;
    assign lv = ch_ctl[W+1].valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (en) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= lv;
            end else if (lv) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (!out_valid_reg || m_tready) begin
                out_data_reg <= res_next;
            end else begin
                skid_data_reg <= res_next;
            end
        end else if (m_tready) begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TW'(out_data_reg[9*W-1:0]);
    assign m_tuser  = out_data_reg[9*W+1:9*W];

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds data while output is empty");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");
    a_sing_offdiag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[2*W-1:W] == '0 && m_tdata[4*W-1:3*W] == '0))
        else $error("singular result not identity");
    a_ready_follows_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready && lv && en) |=> !s_tready)
        else $error("input accepted with full skid register");
`endif

endmodule
